/* hdl/acsf_pkg.sv */
package acsf_pkg;

	localparam int KEYWORD_LEN     = 7;
	localparam int QUEUE_DEPTH_DEF = 2;

	// result kinds
	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_TX      = 2'd1;
	localparam logic [1:0] KIND_REFUSED = 2'd2;

	// parser events
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_STOP  = 2'd2;
	localparam logic [1:0] EV_TEST  = 2'd3;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [7:0] FRAME_HDR [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
	localparam logic [7:0] KW_SAMPLE [KEYWORD_LEN] =
		'{8'h53, 8'h41, 8'h4D, 8'h50, 8'h4C, 8'h45, 8'h3D};
	localparam logic [7:0] KW_TEST [KEYWORD_LEN] =
		'{8'h54, 8'h45, 8'h53, 8'h54, 8'h54, 8'h54, 8'h3D};

	// positions of the transmit bytes of one sample item
	localparam logic [3:0] POS_HDR_FIRST = 4'd0;
	localparam logic [3:0] POS_HDR_LAST  = 4'd3;
	localparam logic [3:0] POS_SAMPLE_LO = 4'd6;
	localparam logic [3:0] POS_SAMPLE_HI = 4'd7;
	localparam logic [3:0] POS_SUM_HI    = 4'd8;
	localparam logic [3:0] POS_SUM_LO    = 4'd9;
	localparam logic [3:0] POS_CNT_HI    = 4'd4;
	localparam logic [3:0] POS_CNT_LO    = 4'd5;

	typedef enum logic [4:0] {
		PS_WAIT_A    = 5'b00001,
		PS_WAIT_T    = 5'b00010,
		PS_WAIT_PLUS = 5'b00100,
		PS_KEYWORD   = 5'b01000,
		PS_PARAM     = 5'b10000
	} parse_state_t;

	typedef struct packed {
		logic               func;
		logic [7:0]         rx_byte;
		logic signed [15:0] sample;
		logic [14:0]        frame_len;
		logic               first_sample;
		logic               last_sample;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic [1:0] event_res;
		logic       last;
	} result_t;

	// one classified item, waiting for the back end
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  ev;
		logic        hdr;
		logic [15:0] cnt;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic        cks;
		logic [15:0] sum;
	} job_t;

endpackage

/* hdl/at_command_and_sample_framer_core.sv */
// Items pass the job queue, then the output register; rates assume result_ready.
// Throughput: a command item gives one result per cycle; a sample gives two
// bytes, eight with the frame header and two more with the checksum, one byte
// per cycle from the back-end sequencer, which sets the rate of sample items.
// The input side keeps taking items while the job queue has room.
// Reset: arst_n clears the parser, sampling flag, frame state and queue at once.
module at_command_and_sample_framer_core
	import acsf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic q_full;
	logic q_push;
	job_t q_data;
	logic q_pop;
	job_t q_head;
	logic q_empty;

	acsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	acsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	acsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* hdl/acsf_queue.sv */
module acsf_queue
	import acsf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");

endmodule

/* hdl/acsf_front.sv */
module acsf_front
	import acsf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  q_full,
	output logic  q_push,
	output job_t  q_data
);

	parse_state_t ps_q, ps_d;
	logic [2:0]   kc_q, kc_d, kc_inc;
	logic [7:0]   kw_q [KEYWORD_LEN];
	logic         kw_we;
	logic         sampling_q, sampling_d;
	logic         in_frame_q, in_frame_d;
	logic [15:0]  sum_q, sum_d, sum_new, sum_base;
	logic         match_test, match_sample;
	logic [1:0]   ev;
	logic         acc;

	assign item_ready = !q_full;
	assign acc        = item_valid && item_ready;
	assign q_push     = acc;
	assign kc_inc     = kc_q + 1'b1;

	always_comb begin
		match_test   = 1'b1;
		match_sample = 1'b1;
		for (int i = 0; i < KEYWORD_LEN; i++) begin
			if (kw_q[i] != KW_TEST[i])   match_test   = 1'b0;
			if (kw_q[i] != KW_SAMPLE[i]) match_sample = 1'b0;
		end
	end

	// command parser
	always_comb begin
		ps_d       = ps_q;
		kc_d       = kc_q;
		kw_we      = 1'b0;
		sampling_d = sampling_q;
		ev         = EV_NONE;
		unique case (ps_q)
			PS_WAIT_A: begin
				ps_d = (item.rx_byte == CH_A) ? PS_WAIT_T : PS_WAIT_A;
			end
			PS_WAIT_T: begin
				if (item.rx_byte == CH_T) begin
					ps_d = PS_WAIT_PLUS;
				end else if (item.rx_byte == CH_A) begin
					ps_d = PS_WAIT_T;
				end else begin
					ps_d = PS_WAIT_A;
				end
			end
			PS_WAIT_PLUS: begin
				if (item.rx_byte == CH_PLUS) begin
					ps_d = PS_KEYWORD;
					kc_d = '0;
				end else begin
					ps_d = PS_WAIT_A;
				end
			end
			PS_KEYWORD: begin
				kw_we = 1'b1;
				kc_d  = kc_inc;
				if (kc_inc == 3'(KEYWORD_LEN)) begin
					ps_d = PS_PARAM;
				end
			end
			PS_PARAM: begin
				if (match_test) begin
					ev = EV_TEST;
				end else if (match_sample) begin
					if (item.rx_byte == CH_ONE) begin
						sampling_d = 1'b1;
						ev         = EV_START;
					end else begin
						sampling_d = 1'b0;
						ev         = EV_STOP;
					end
				end
				ps_d = PS_WAIT_A;
			end
			default: begin
				ps_d = PS_WAIT_A;
			end
		endcase
	end

	// sample classifier
	assign sum_base = item.first_sample ? 16'h0000 : sum_q;
	assign sum_new  = sum_base + {8'h00, item.sample[7:0]} + {8'h00, item.sample[15:8]};

	always_comb begin
		q_data      = '0;
		in_frame_d  = in_frame_q;
		sum_d       = sum_q;
		if (!item.func) begin
			q_data.kind = KIND_ACK;
			q_data.ev   = ev;
		end else if (item.first_sample && !sampling_q) begin
			q_data.kind = KIND_REFUSED;
			in_frame_d  = 1'b0;
			sum_d       = '0;
		end else if (!item.first_sample && !in_frame_q) begin
			q_data.kind = KIND_REFUSED;
		end else begin
			q_data.kind = KIND_TX;
			q_data.hdr  = item.first_sample;
			q_data.cnt  = {item.frame_len, 1'b0};
			q_data.lo   = item.sample[7:0];
			q_data.hi   = item.sample[15:8];
			q_data.cks  = item.last_sample;
			q_data.sum  = sum_new;
			if (item.last_sample) begin
				in_frame_d = 1'b0;
				sum_d      = '0;
			end else begin
				in_frame_d = 1'b1;
				sum_d      = sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !item.func && kw_we) begin
			kw_q[kc_q] <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q       <= PS_WAIT_A;
			kc_q       <= '0;
			sampling_q <= 1'b0;
			in_frame_q <= 1'b0;
			sum_q      <= '0;
		end else if (acc) begin
			if (!item.func) begin
				ps_q       <= ps_d;
				kc_q       <= kc_d;
				sampling_q <= sampling_d;
			end else begin
				in_frame_q <= in_frame_d;
				sum_q      <= sum_d;
			end
		end
	end

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> sum_q == '0)
		else $error("byte sum left over outside a frame");

	a_refused_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.func && item.first_sample && !sampling_q |=> !in_frame_q)
		else $error("frame opened while sampling off");

	a_keyword_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !item.func && ps_q == PS_KEYWORD && kc_q == 3'(KEYWORD_LEN - 1)
		|=> ps_q == PS_PARAM)
		else $error("keyword end missed");

endmodule

/* hdl/acsf_back.sv */
module acsf_back
	import acsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  job_t    q_head,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic [3:0] pos_q;
	logic [3:0] idx;
	logic [7:0] byte_sel;
	logic       is_last;
	logic       out_load;
	logic       valid_q;
	result_t    result_q;

	assign idx      = q_head.hdr ? pos_q : pos_q + POS_SAMPLE_LO;
	assign out_load = !q_empty && (!valid_q || result_ready);
	assign is_last  = (q_head.kind != KIND_TX) || (idx == POS_SUM_LO)
		|| (idx == POS_SAMPLE_HI && !q_head.cks);
	assign q_pop    = out_load && is_last;

	always_comb begin
		unique case (idx) inside
			[POS_HDR_FIRST:POS_HDR_LAST]: byte_sel = FRAME_HDR[idx[1:0]];
			POS_CNT_HI:                   byte_sel = q_head.cnt[15:8];
			POS_CNT_LO:                   byte_sel = q_head.cnt[7:0];
			POS_SAMPLE_LO:                byte_sel = q_head.lo;
			POS_SAMPLE_HI:                byte_sel = q_head.hi;
			POS_SUM_HI:                   byte_sel = q_head.sum[15:8];
			POS_SUM_LO:                   byte_sel = q_head.sum[7:0];
			default:                      byte_sel = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.kind      <= q_head.kind;
			result_q.tx_byte   <= (q_head.kind == KIND_TX) ? byte_sel : 8'h00;
			result_q.event_res <= q_head.ev;
			result_q.last      <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			if (out_load) begin
				pos_q <= is_last ? '0 : pos_q + 1'b1;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx <= POS_SUM_LO)
		else $error("byte position out of range");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_q && result_q.last)
		else $error("job retired without last result");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && q_head.kind != KIND_TX |-> pos_q == '0)
		else $error("acknowledge or refusal spans several results");

endmodule
